>>> rtl/core/kufea_pkg.sv
// ----------------------------------------------------------------------------
// kufea_pkg
// Shared types and constants for the Kruskal union-find edge acceptor.
// ----------------------------------------------------------------------------
`default_nettype none

package kufea_pkg;

  // Default parameter values
  localparam int MAX_NODES_DEF   = 16;
  localparam int LENGTH_BITS_DEF = 10;

  // Fixed field widths
  localparam int NODE_FIELD_W = 4;
  localparam int SUM_W        = 16;
  localparam int COUNT_W      = 4;
  localparam int RANK_W       = 3;
  localparam int NC_W         = 5;

  // Saturation limits
  localparam logic [SUM_W-1:0]   SUM_MAX   = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'hF;
  localparam logic [RANK_W-1:0]  RANK_MAX  = 3'h7;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [NC_W-1:0] NODE_COUNT_RST = 5'd16;
  localparam logic [0:0]      REG_NODE_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_COMP,
    ST_LINK,
    ST_BUMP,
    ST_RESP
  } state_e;

endpackage : kufea_pkg

`default_nettype wire

>>> rtl/core/kufea_ifs.sv
// ----------------------------------------------------------------------------
// kufea_ifs
// Valid/ready channels: edge input and result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface kufea_edge_if #(
  parameter int LENGTH_BITS = kufea_pkg::LENGTH_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [kufea_pkg::NODE_FIELD_W-1:0] node_a;
  logic [kufea_pkg::NODE_FIELD_W-1:0] node_b;
  logic [LENGTH_BITS-1:0]            edge_length;

  modport source (output valid, node_a, node_b, edge_length, input ready);
  modport sink   (input valid, node_a, node_b, edge_length, output ready);
endinterface : kufea_edge_if

interface kufea_result_if ();
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [kufea_pkg::SUM_W-1:0]   total_length;
  logic [kufea_pkg::COUNT_W-1:0] edges_taken;
  logic                          tree_complete;

  modport source (output valid, accepted, total_length, edges_taken, tree_complete,
                  input ready);
  modport sink   (input valid, accepted, total_length, edges_taken, tree_complete,
                  output ready);
endinterface : kufea_result_if

`default_nettype wire

>>> rtl/core/kruskal_union_find_edge_acceptor.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_acceptor
// Kruskal edge acceptor over a disjoint-set forest (union by rank, full path
// compression) with a saturating total of accepted edge lengths.
// ----------------------------------------------------------------------------
// Usage:
//   edge_i   : one transfer per edge (node_a, node_b, edge_length), edges in
//              non-decreasing length order. ready is high only while idle.
//   result_o : exactly one transfer per edge: accepted, running total
//              (saturates at 65535), edges taken (saturates at 15) and
//              tree_complete (edges taken == clamped node_count - 1).
//   APB port : register 0 (byte 0) = node_count, 5 bits, reset 16. Write only
//              while no edge is in flight.
// Sequence: one item walks a shared sequencer over a single-port-read forest
//   RAM: FIND and COMP for node_a, FIND and COMP for node_b, LINK, BUMP only
//   when a rank is raised, then RESP; an edge with an endpoint outside
//   node_count goes from IDLE straight to RESP. Each parent hop costs one RAM
//   read for the find and one read/write for the compression pass.
// Reset: every node is its own root of rank 0 (tracked by per-node valid
//   bits, no clearing pass), totals clear, node_count = 16.
// Stall: the finished result sits in an output register; the next edge is
//   taken while it waits. A second result waits in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_acceptor #(
  parameter int MAX_NODES   = kufea_pkg::MAX_NODES_DEF,
  parameter int LENGTH_BITS = kufea_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  kufea_edge_if.sink                            edge_i,
  kufea_result_if.source                        result_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [kufea_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [kufea_pkg::CFG_DATA_W-1:0] pwdata,
  output      logic [kufea_pkg::CFG_DATA_W-1:0] prdata,
  output      logic                             pready
);

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int RANK_W    = kufea_pkg::RANK_W;
  localparam int WORD_W    = RANK_W + NODE_W;
  localparam int SUM_W     = kufea_pkg::SUM_W;
  localparam int COUNT_W   = kufea_pkg::COUNT_W;
  localparam int NC_W      = kufea_pkg::NC_W;
  localparam int SUM_EXT_W = ((LENGTH_BITS > SUM_W) ? LENGTH_BITS : SUM_W) + 1;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [NC_W-1:0] node_count_q;
  logic            cfg_wr;
  logic            cfg_hit;

  assign cfg_hit = (paddr[kufea_pkg::CFG_ADDR_W-1:2] == kufea_pkg::REG_NODE_COUNT);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? kufea_pkg::CFG_DATA_W'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= kufea_pkg::NODE_COUNT_RST;
    end else if (cfg_wr) begin
      node_count_q <= pwdata[NC_W-1:0];
    end
  end

  // Effective node count, clamped to 1..MAX_NODES
  logic [NC_W-1:0] limit;
  always_comb begin
    limit = node_count_q;
    if (node_count_q == '0) begin
      limit = NC_W'(1);
    end else if (32'(node_count_q) > 32'(MAX_NODES)) begin
      limit = NC_W'(MAX_NODES);
    end
  end

  // --------------------------------------------------------------------------
  // Forest RAM: word = {rank, parent}. An entry never written reads as its
  // reset value (own parent, rank 0) via valid_q.
  // --------------------------------------------------------------------------
  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [NODE_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [MAX_NODES-1:0] valid_q;

  kufea_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_NODES)
  ) u_forest (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  kufea_pkg::state_e state_q, state_d;

  logic [NODE_W-1:0]      cur_q, cur_d;       // node whose word is on ram_rdata
  logic [NODE_W-1:0]      start_q, start_d;   // endpoint of the current walk
  logic [NODE_W-1:0]      root_q, root_d;     // root of the current side
  logic [NODE_W-1:0]      root_a_q, root_a_d;
  logic [RANK_W-1:0]      rank_a_q, rank_a_d;
  logic [RANK_W-1:0]      rank_b_q, rank_b_d;
  logic [NODE_W-1:0]      b_q, b_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   side_q, side_d;     // 0: node_a, 1: node_b
  logic                   acc_q, acc_d;

  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [COUNT_W-1:0]     count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  logic                   out_acc_q;
  logic [SUM_W-1:0]       out_sum_q;
  logic [COUNT_W-1:0]     out_cnt_q;
  logic                   out_done_q;
  logic                   out_load;

  // Current word as seen through the valid bits
  logic [NODE_W-1:0] par_view;
  logic [RANK_W-1:0] rank_view;
  assign par_view  = valid_q[cur_q] ? ram_rdata[NODE_W-1:0] : cur_q;
  assign rank_view = valid_q[cur_q] ? ram_rdata[WORD_W-1 -: RANK_W] : '0;

  // Saturating adder for the length total
  logic [SUM_EXT_W-1:0] sum_ext;
  logic [SUM_W-1:0]     sum_sat;
  assign sum_ext = SUM_EXT_W'(sum_q) + SUM_EXT_W'(len_q);
  assign sum_sat = (sum_ext > SUM_EXT_W'(kufea_pkg::SUM_MAX)) ? kufea_pkg::SUM_MAX
                                                              : sum_ext[SUM_W-1:0];

  logic in_range;
  assign in_range = ({1'b0, edge_i.node_a} < limit) && ({1'b0, edge_i.node_b} < limit);

  assign edge_i.ready = (state_q == kufea_pkg::ST_IDLE);

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    start_d   = start_q;
    root_d    = root_q;
    root_a_d  = root_a_q;
    rank_a_d  = rank_a_q;
    rank_b_d  = rank_b_q;
    b_d       = b_q;
    len_d     = len_q;
    side_d    = side_q;
    acc_d     = acc_q;
    sum_d     = sum_q;
    count_d   = count_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = {rank_view, root_q};
    ram_raddr = cur_q;
    out_load  = 1'b0;

    case (state_q)
      kufea_pkg::ST_IDLE: begin
        if (edge_i.valid) begin
          b_d     = NODE_W'(edge_i.node_b);
          len_d   = edge_i.edge_length;
          acc_d   = 1'b0;
          side_d  = 1'b0;
          cur_d   = NODE_W'(edge_i.node_a);
          start_d = NODE_W'(edge_i.node_a);
          ram_raddr = NODE_W'(edge_i.node_a);
          state_d = in_range ? kufea_pkg::ST_FIND : kufea_pkg::ST_RESP;
        end
      end

      // Walk up to the root, one parent hop per cycle
      kufea_pkg::ST_FIND: begin
        if (par_view == cur_q) begin
          root_d = cur_q;
          if (!side_q) begin
            root_a_d = cur_q;
            rank_a_d = rank_view;
          end else begin
            rank_b_d = rank_view;
          end
          cur_d     = start_q;
          ram_raddr = start_q;
          state_d   = kufea_pkg::ST_COMP;
        end else begin
          cur_d     = par_view;
          ram_raddr = par_view;
        end
      end

      // Second pass: repoint every node on the path at the root, then go to node_b or LINK
      kufea_pkg::ST_COMP: begin
        if (cur_q == root_q) begin
          if (!side_q) begin
            side_d    = 1'b1;
            cur_d     = b_q;
            start_d   = b_q;
            ram_raddr = b_q;
            state_d   = kufea_pkg::ST_FIND;
          end else begin
            state_d = kufea_pkg::ST_LINK;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur_q;
          ram_wdata = {rank_view, root_q};
          cur_d     = par_view;
          ram_raddr = par_view;
        end
      end

      // Union by rank plus total and count update; root_q holds the root of node_b
      kufea_pkg::ST_LINK: begin
        state_d = kufea_pkg::ST_RESP;
        if (root_a_q != root_q) begin
          acc_d   = 1'b1;
          sum_d   = sum_sat;
          count_d = (count_q == kufea_pkg::COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
          ram_we  = 1'b1;
          if (rank_a_q > rank_b_q) begin
            ram_waddr = root_q;
            ram_wdata = {rank_b_q, root_a_q};
          end else begin
            ram_waddr = root_a_q;
            ram_wdata = {rank_a_q, root_q};
            if ((rank_a_q == rank_b_q) && (rank_b_q != kufea_pkg::RANK_MAX)) begin
              state_d = kufea_pkg::ST_BUMP;
            end
          end
        end
      end

      // Tie: raise the rank of node_b's root
      kufea_pkg::ST_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = root_q;
        ram_wdata = {rank_b_q + RANK_W'(1), root_q};
        state_d   = kufea_pkg::ST_RESP;
      end

      kufea_pkg::ST_RESP: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = kufea_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = kufea_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kufea_pkg::ST_IDLE;
      side_q      <= 1'b0;
      acc_q       <= 1'b0;
      sum_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      side_q      <= side_d;
      acc_q       <= acc_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    start_q  <= start_d;
    root_q   <= root_d;
    root_a_q <= root_a_d;
    rank_a_q <= rank_a_d;
    rank_b_q <= rank_b_d;
    b_q      <= b_d;
    len_q    <= len_d;
    if (out_load) begin
      out_acc_q  <= acc_q;
      out_sum_q  <= sum_q;
      out_cnt_q  <= count_q;
      out_done_q <= ({1'b0, count_q} == (limit - NC_W'(1)));
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.accepted      = out_acc_q;
  assign result_o.total_length  = out_sum_q;
  assign result_o.edges_taken   = out_cnt_q;
  assign result_o.tree_complete = out_done_q;

`ifndef NO_ASSERTIONS
  // Compression never writes the node being fetched in the same cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kufea_pkg::ST_COMP && ram_we) |-> (ram_waddr != ram_raddr))
    else $error("forest RAM read/write collision");

  // Running total only grows
  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q >= $past(sum_q))
    else $error("length total decreased");

  // Edge count steps by at most one per item
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == $past(count_q)) || (count_q == $past(count_q) + COUNT_W'(1)))
    else $error("edge count jumped");

  // An accepted edge always reports a nonzero edge count
  a_acc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.accepted) |-> (result_o.edges_taken != '0))
    else $error("accepted edge with zero edge count");

  // A result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || result_o.ready))
    else $error("result overwritten before transfer");
`endif

endmodule : kruskal_union_find_edge_acceptor

`default_nettype wire

>>> rtl/core/kufea_ram.sv
// ----------------------------------------------------------------------------
// kufea_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kufea_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule : kufea_ram

`default_nettype wire

>>> tb/kruskal_union_find_edge_acceptor_test.sv
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_acceptor_test
// Self-checking bench for the Kruskal edge acceptor. Edges go in through a
// queue-fed driver and results are checked against an in-bench disjoint-set
// predictor, with random gaps and stalls on both channels and node_count
// changed between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module kruskal_union_find_edge_acceptor_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES   = kufea_pkg::MAX_NODES_DEF;
  localparam int LENGTH_BITS = kufea_pkg::LENGTH_BITS_DEF;

  localparam int NODE_FIELD_W = kufea_pkg::NODE_FIELD_W;
  localparam int SUM_W        = kufea_pkg::SUM_W;
  localparam int COUNT_W      = kufea_pkg::COUNT_W;
  localparam int RANK_W       = kufea_pkg::RANK_W;
  localparam int NC_W         = kufea_pkg::NC_W;
  localparam int CFG_ADDR_W   = kufea_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W   = kufea_pkg::CFG_DATA_W;

  localparam logic [SUM_W-1:0]   SUM_MAX        = kufea_pkg::SUM_MAX;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = kufea_pkg::COUNT_MAX;
  localparam logic [RANK_W-1:0]  RANK_MAX       = kufea_pkg::RANK_MAX;
  localparam logic [NC_W-1:0]    NODE_COUNT_RST = kufea_pkg::NODE_COUNT_RST;
  localparam logic [0:0]         REG_NODE_COUNT = kufea_pkg::REG_NODE_COUNT;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] node_a;
    logic [NODE_FIELD_W-1:0] node_b;
    logic [LENGTH_BITS-1:0]  edge_length;
  } edge_t;

  typedef struct packed {
    logic               accepted;
    logic [SUM_W-1:0]   total_length;
    logic [COUNT_W-1:0] edges_taken;
    logic               tree_complete;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  // APB side
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  kufea_edge_if #(.LENGTH_BITS(LENGTH_BITS)) edge_if ();
  kufea_result_if result_if ();

  kruskal_union_find_edge_acceptor #(
    .MAX_NODES  (MAX_NODES),
    .LENGTH_BITS(LENGTH_BITS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .edge_i  (edge_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the forest, the totals and node_count
  // --------------------------------------------------------------------------
  logic [NODE_FIELD_W-1:0] forest_parent [MAX_NODES];
  logic [RANK_W-1:0]       forest_rank   [MAX_NODES];
  logic [SUM_W-1:0]        span_total;
  logic [COUNT_W-1:0]      span_edges;
  logic [NC_W-1:0]         node_count_cfg;

  edge_t    edge_backlog [$];  // edges waiting for the driver
  verdict_t verdict_fifo [$];  // predicted results, oldest first

  int unsigned fault_count = 0;
  int unsigned send_gap    = 0;
  int unsigned send_calm   = 0;
  int unsigned recv_stall  = 0;
  int unsigned recv_calm   = 0;

  // node_count is clamped to 1..MAX_NODES before use
  function automatic logic [NC_W-1:0] clamp_span(input logic [NC_W-1:0] count);
    if (count == '0) return NC_W'(1);
    if (count > NC_W'(MAX_NODES)) return NC_W'(MAX_NODES);
    return count;
  endfunction

  // Root lookup with full path compression: every node walked ends up
  // pointing straight at the root.
  function automatic logic [NODE_FIELD_W-1:0] find_root(input logic [NODE_FIELD_W-1:0] node);
    logic [NODE_FIELD_W-1:0] root;
    logic [NODE_FIELD_W-1:0] cur;
    logic [NODE_FIELD_W-1:0] hop;
    root = node;
    for (int s = 0; s < MAX_NODES && forest_parent[root] != root; s++)
      root = forest_parent[root];
    cur = node;
    for (int s = 0; s < MAX_NODES && cur != root; s++) begin
      hop = forest_parent[cur];
      forest_parent[cur] = root;
      cur = hop;
    end
    return root;
  endfunction

  // One edge through the acceptor: range check, two finds, union by rank.
  function automatic verdict_t kruskal_step(input edge_t e);
    logic [NC_W-1:0]         span;
    logic [NODE_FIELD_W-1:0] ra;
    logic [NODE_FIELD_W-1:0] rb;
    logic [NODE_FIELD_W-1:0] swap;
    logic [SUM_W:0]          sum_wide;
    verdict_t                v;
    span = clamp_span(node_count_cfg);
    v.accepted = 1'b0;
    // out-of-range endpoints leave the forest untouched
    if (NC_W'(e.node_a) < span && NC_W'(e.node_b) < span) begin
      ra = find_root(e.node_a);
      rb = find_root(e.node_b);
      if (ra != rb) begin
        v.accepted = 1'b1;
        sum_wide   = {1'b0, span_total} + (SUM_W+1)'(e.edge_length);
        span_total = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        if (span_edges != COUNT_MAX) span_edges++;
        // lower rank goes under; on a tie node_a's root goes under node_b's
        if (forest_rank[ra] > forest_rank[rb]) begin
          swap = ra;
          ra   = rb;
          rb   = swap;
        end
        forest_parent[ra] = rb;
        if (forest_rank[ra] == forest_rank[rb] && forest_rank[rb] != RANK_MAX)
          forest_rank[rb]++;
      end
    end
    v.total_length  = span_total;
    v.edges_taken   = span_edges;
    v.tree_complete = ({1'b0, span_edges} == span - 1'b1);
    return v;
  endfunction

  // Idle lengths: mostly none or short, a few long, and now and then a
  // calm stretch with no idling at all.
  function automatic int unsigned next_pause(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_field(input string label, input logic [SUM_W-1:0] want,
                            input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fault_count++;
    end
  endtask

  task automatic queue_edge(input int unsigned a, input int unsigned b, input int unsigned len);
    edge_t e;
    e.node_a      = NODE_FIELD_W'(a);
    e.node_b      = NODE_FIELD_W'(b);
    e.edge_length = LENGTH_BITS'(len);
    edge_backlog.push_back(e);
  endtask

  // Quiet means nothing queued, nothing offered and nothing outstanding.
  // Checked on the falling edge so all clocked updates have settled.
  task automatic wait_quiet();
    @(negedge clk_i);
    while (edge_backlog.size() != 0 || edge_if.valid || verdict_fifo.size() != 0)
      @(negedge clk_i);
  endtask

  // APB write of node_count: setup then access; the register takes the data
  // at the edge where psel, penable, pwrite and pready are all high.
  task automatic set_node_count(input logic [NC_W-1:0] count);
    wait_quiet();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({REG_NODE_COUNT, 2'b00});
    pwdata  <= CFG_DATA_W'(count);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    node_count_cfg = count;
    @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Edge driver: offers the next queued edge once the previous transfer is
  // done and the current gap has run out. Prediction happens at the transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : edge_driver
    edge_t nxt;
    if (!rst_ni) begin
      edge_if.valid <= 1'b0;
    end else begin
      if (edge_if.valid && edge_if.ready === 1'b1) begin
        nxt.node_a      = edge_if.node_a;
        nxt.node_b      = edge_if.node_b;
        nxt.edge_length = edge_if.edge_length;
        verdict_fifo.push_back(kruskal_step(nxt));
      end
      if (!edge_if.valid || edge_if.ready === 1'b1) begin
        if (send_gap != 0) begin
          edge_if.valid <= 1'b0;
          send_gap--;
        end else if (edge_backlog.size() != 0) begin
          nxt = edge_backlog.pop_front();
          edge_if.node_a      <= nxt.node_a;
          edge_if.node_b      <= nxt.node_b;
          edge_if.edge_length <= nxt.edge_length;
          edge_if.valid       <= 1'b1;
          send_gap = next_pause(send_calm);
        end else begin
          edge_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each result transfer against the oldest
  // prediction and throttles ready with random stalls.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_monitor
    verdict_t want;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid === 1'b1 && result_if.ready) begin
        if (verdict_fifo.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual acc=%0b total=%0d edges=%0d done=%0b",
                   $time, result_if.accepted, result_if.total_length,
                   result_if.edges_taken, result_if.tree_complete);
          fault_count++;
        end else begin
          want = verdict_fifo.pop_front();
          flag_field("accepted", SUM_W'(want.accepted), SUM_W'(result_if.accepted));
          flag_field("total_length", want.total_length, result_if.total_length);
          flag_field("edges_taken", SUM_W'(want.edges_taken), SUM_W'(result_if.edges_taken));
          flag_field("tree_complete", SUM_W'(want.tree_complete),
                     SUM_W'(result_if.tree_complete));
        end
      end
      if (recv_stall != 0) begin
        result_if.ready <= 1'b0;
        recv_stall--;
      end else begin
        result_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 20) recv_stall = next_pause(recv_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned nc_plan [10];
    int unsigned span_now;
    int unsigned len_run;
    int unsigned step;
    int unsigned a;
    int unsigned b;

    // every DUT input known from time zero, reset held low
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    edge_if.valid       = 1'b0;
    edge_if.node_a      = '0;
    edge_if.node_b      = '0;
    edge_if.edge_length = '0;
    result_if.ready     = 1'b0;

    // predictor starts from the reset forest
    for (int i = 0; i < MAX_NODES; i++) begin
      forest_parent[i] = NODE_FIELD_W'(i);
      forest_rank[i]   = '0;
    end
    span_total     = '0;
    span_edges     = '0;
    node_count_cfg = NODE_COUNT_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // reset node_count: top node usable, zero length, self loop
    queue_edge(15, 0, 0);
    queue_edge(0, 0, 0);

    // four nodes: range checks on either endpoint, max length, tree
    // completes then overshoots, rejected cycle, out-of-order length
    set_node_count(NC_W'(4));
    queue_edge(0, 1, 5);
    queue_edge(5, 2, 6);
    queue_edge(2, 9, 7);
    queue_edge(2, 3, 1023);
    queue_edge(1, 3, 1023);
    queue_edge(3, 15, 1023);
    queue_edge(4, 4, 1023);
    queue_edge(3, 0, 2);
    queue_edge(1, 1, 3);

    // zero clamps up to one node: nothing is in a set with anything
    set_node_count(NC_W'(0));
    queue_edge(0, 0, 0);
    queue_edge(0, 1, 9);

    set_node_count(NC_W'(1));
    queue_edge(0, 0, 1023);

    // above MAX_NODES clamps down
    set_node_count(NC_W'(31));
    queue_edge(14, 13, 10);
    queue_edge(12, 15, 11);
    queue_edge(14, 15, 12);
    queue_edge(13, 12, 20);
    queue_edge(9, 10, 0);

    set_node_count(NC_W'(17));
    queue_edge(10, 11, 30);
    queue_edge(6, 7, 31);

    // ---- random part ----
    // mostly in-range edges with slowly rising lengths, some noise
    nc_plan = '{2, 8, 12, 16, 31, 5, 16, 20, 0, 16};
    len_run = 0;
    foreach (nc_plan[p]) begin
      set_node_count(NC_W'(nc_plan[p]));
      span_now = 32'(clamp_span(NC_W'(nc_plan[p])));
      repeat (48) begin
        if ($urandom_range(0, 99) < 85) begin
          a = $urandom_range(0, span_now - 1);
          b = $urandom_range(0, span_now - 1);
        end else begin
          a = $urandom_range(0, MAX_NODES - 1);
          b = $urandom_range(0, MAX_NODES - 1);
        end
        if ($urandom_range(0, 99) < 8) begin
          len_run = $urandom_range(0, 1023);
        end else begin
          step = $urandom_range(0, 6);
          // past the top the sequence restarts low, i.e. out of order
          if (len_run + step > 1023) len_run = $urandom_range(0, 40);
          else len_run += step;
        end
        queue_edge(a, b, len_run);
      end
    end

    // drain, then give stray results a chance to show up
    wait_quiet();
    repeat (40) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule : kruskal_union_find_edge_acceptor_test

`default_nettype wire
